@@ src/cqs_pkg.sv @@
// Package with the sizes, codes and state type of the coordinate queue.
`timescale 1ns / 1ps
package cqs_pkg;

  // Queue geometry.
  localparam int DEPTH   = 64;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  // Field widths of the request and response.
  localparam int KIND_W   = 3;
  localparam int COORD_W  = 16;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  // Operation codes carried in the kind field.
  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND      = 3'd0,
    KIND_POP         = 3'd1,
    KIND_SEARCH_ALL  = 3'd2,
    KIND_SEARCH_EXCL = 3'd3,
    KIND_PEEK        = 3'd4
  } kind_t;

  // Status codes of a response.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

endpackage

@@ src/cqs_if.sv @@
// Request and response channel interfaces of the coordinate queue.
`timescale 1ns / 1ps
interface cqs_req_if import cqs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;

  modport source (output valid, kind, coord_x, coord_y, input ready);
  modport sink (input valid, kind, coord_x, coord_y, output ready);
endinterface

interface cqs_rsp_if import cqs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic signed [COORD_W-1:0] tail_x;
  logic signed [COORD_W-1:0] tail_y;
  logic [COUNT_W-1:0]        entry_count;
  logic [STATUS_W-1:0]       status;

  modport source (output valid, found, tail_x, tail_y, entry_count, status, input ready);
  modport sink (input valid, found, tail_x, tail_y, entry_count, status, output ready);
endinterface

@@ src/cqs_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module cqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/coordinate_queue_with_search.sv @@
// Top level: bounded FIFO of coordinate pairs with a serial membership search.
//
//   channel  dir  payload                                       handshake
//   req      in   kind, coord_x, coord_y                        valid / ready
//   rsp      out  found, tail_x, tail_y, entry_count, status    valid / ready
//
// Append, pop, peek and searches over no entries give their response in the cycle
// after the request. A search reads one entry per cycle through the single read
// port of the entry store and one pair comparator. Reset clears the count, the
// oldest slot and the sequencer; the entry store holds no reset value. req.ready
// is low during a scan and while a response waits to be taken.
`timescale 1ns / 1ps
module coordinate_queue_with_search import cqs_pkg::*; (
  input logic      clk,
  input logic      rst,
  cqs_req_if.sink  req,
  cqs_rsp_if.source rsp
);

  // Slot a given number of places after a base slot, wrapping at DEPTH.
  function automatic logic [IDX_W-1:0] slot_after(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  state_t                    state, state_next;
  logic [CNT_W-1:0]          count, count_next;
  logic [IDX_W-1:0]          oldest, oldest_next;
  logic [COORD_W-1:0]        tail_x, tail_x_next;
  logic [COORD_W-1:0]        tail_y, tail_y_next;
  logic [COORD_W-1:0]        key_x, key_x_next;
  logic [COORD_W-1:0]        key_y, key_y_next;
  logic [IDX_W-1:0]          scan_slot, scan_slot_next;
  logic [CNT_W-1:0]          scan_left, scan_left_next;
  logic                      rd_pending, rd_pending_next;
  logic                      hit, hit_next;
  logic                      rsp_valid, rsp_valid_next;
  logic                      rsp_found, rsp_found_next;
  logic [COORD_W-1:0]        rsp_tail_x, rsp_tail_x_next;
  logic [COORD_W-1:0]        rsp_tail_y, rsp_tail_y_next;
  logic [CNT_W-1:0]          rsp_count, rsp_count_next;
  status_t                   rsp_status, rsp_status_next;

  logic                      accept;
  logic                      finish;
  logic                      finish_found;
  status_t                   finish_status;
  logic [CNT_W-1:0]          covered;
  logic                      match;
  logic                      ram_we;
  logic [IDX_W-1:0]          ram_wr_addr;
  logic                      ram_re;
  logic [2*COORD_W-1:0]      ram_rd_data;

  // Entry store: x in the upper half, y in the lower half.
  cqs_ram #(
    .WIDTH (2 * COORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data ({key_x_next, key_y_next}),
    .rd_en   (ram_re),
    .rd_addr (scan_slot),
    .rd_data (ram_rd_data)
  );

  assign accept = req.valid && req.ready;
  assign req.ready = (state == S_IDLE) && (!rsp_valid || rsp.ready);

  // The shared pair comparator.
  assign match = rd_pending && (ram_rd_data == {key_x, key_y});

  // Sequencer: next state, queue update and response load.
  always_comb begin
    state_next      = state;
    count_next      = count;
    oldest_next     = oldest;
    tail_x_next     = tail_x;
    tail_y_next     = tail_y;
    key_x_next      = key_x;
    key_y_next      = key_y;
    scan_slot_next  = scan_slot;
    scan_left_next  = scan_left;
    rd_pending_next = 1'b0;
    hit_next        = hit;
    rsp_valid_next  = rsp_valid && !rsp.ready;
    rsp_found_next  = rsp_found;
    rsp_tail_x_next = rsp_tail_x;
    rsp_tail_y_next = rsp_tail_y;
    rsp_count_next  = rsp_count;
    rsp_status_next = rsp_status;
    finish          = 1'b0;
    finish_found    = 1'b0;
    finish_status   = STATUS_OK;
    covered         = '0;
    ram_we          = 1'b0;
    ram_wr_addr     = slot_after(oldest, count);
    ram_re          = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          key_x_next = req.coord_x;
          key_y_next = req.coord_y;
          finish     = 1'b1;
          unique case (kind_t'(req.kind))
            KIND_APPEND: begin
              if (count == CNT_W'(DEPTH)) begin
                finish_status = STATUS_FULL;
              end else begin
                ram_we      = 1'b1;
                count_next  = count + 1'b1;
                tail_x_next = req.coord_x;
                tail_y_next = req.coord_y;
              end
            end
            KIND_POP: begin
              if (count == '0) begin
                finish_status = STATUS_EMPTY;
              end else begin
                count_next  = count - 1'b1;
                oldest_next = (count == CNT_W'(1)) ? '0 : slot_after(oldest, CNT_W'(1));
              end
            end
            KIND_SEARCH_ALL: begin
              covered = count;
            end
            KIND_SEARCH_EXCL: begin
              covered = (count > CNT_W'(1)) ? count - 1'b1 : '0;
            end
            default: begin
            end
          endcase
          // A search over at least one entry goes on to the scan.
          if (covered != '0) begin
            finish         = 1'b0;
            state_next     = S_SCAN;
            scan_left_next = covered;
            scan_slot_next = oldest;
            hit_next       = 1'b0;
          end
        end
      end
      S_SCAN: begin
        hit_next = hit || match;
        if (scan_left != '0) begin
          ram_re          = 1'b1;
          scan_slot_next  = slot_after(scan_slot, CNT_W'(1));
          scan_left_next  = scan_left - 1'b1;
          rd_pending_next = 1'b1;
        end else if (!rd_pending) begin
          finish       = 1'b1;
          finish_found = hit;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Load the response register.
    if (finish) begin
      rsp_valid_next  = 1'b1;
      rsp_found_next  = finish_found;
      rsp_count_next  = count_next;
      rsp_status_next = finish_status;
      rsp_tail_x_next = (count_next == '0) ? '0 : tail_x_next;
      rsp_tail_y_next = (count_next == '0) ? '0 : tail_y_next;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      oldest     <= '0;
      rd_pending <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      oldest     <= oldest_next;
      rd_pending <= rd_pending_next;
      rsp_valid  <= rsp_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    tail_x     <= tail_x_next;
    tail_y     <= tail_y_next;
    key_x      <= key_x_next;
    key_y      <= key_y_next;
    scan_slot  <= scan_slot_next;
    scan_left  <= scan_left_next;
    hit        <= hit_next;
    rsp_found  <= rsp_found_next;
    rsp_tail_x <= rsp_tail_x_next;
    rsp_tail_y <= rsp_tail_y_next;
    rsp_count  <= rsp_count_next;
    rsp_status <= rsp_status_next;
  end

  // Response port.
  assign rsp.valid       = rsp_valid;
  assign rsp.found       = rsp_found;
  assign rsp.tail_x      = rsp_tail_x;
  assign rsp.tail_y      = rsp_tail_y;
  assign rsp.entry_count = COUNT_W'(rsp_count);
  assign rsp.status      = rsp_status;

endmodule

@@ tb/coord_queue_checker.sv @@
// Checker that predicts and compares every response of the coordinate queue.
`timescale 1ns / 1ps
module coord_queue_checker import cqs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  cqs_req_if          req,
  cqs_rsp_if          rsp,
  output int unsigned mismatch_count,
  output int unsigned replies_outstanding
);

  // One predicted response.
  typedef struct packed {
    logic                found;
    logic [COORD_W-1:0]  tail_x;
    logic [COORD_W-1:0]  tail_y;
    logic [COUNT_W-1:0]  entry_count;
    status_t             status;
  } queue_reply_t;

  // Shadow copy of the queue contents.
  logic [COORD_W-1:0] x_mem [DEPTH];
  logic [COORD_W-1:0] y_mem [DEPTH];
  int unsigned        oldest_slot;
  int unsigned        held_count;

  queue_reply_t pending_replies [$];
  queue_reply_t want;

  // True if the pair sits in the first "covered" entries from the oldest one.
  function automatic logic pair_held(input int unsigned covered,
                                     input logic [COORD_W-1:0] px,
                                     input logic [COORD_W-1:0] py);
    int unsigned slot;
    for (int unsigned k = 0; k < covered; k++) begin
      slot = (oldest_slot + k) % DEPTH;
      if (x_mem[slot] == px && y_mem[slot] == py) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Applies one request to the shadow queue and returns the response it causes.
  function automatic queue_reply_t apply_queue_op(input logic [KIND_W-1:0]  kind,
                                                  input logic [COORD_W-1:0] px,
                                                  input logic [COORD_W-1:0] py);
    queue_reply_t r;
    int unsigned  slot;
    r = '{found: 1'b0, tail_x: '0, tail_y: '0, entry_count: '0, status: STATUS_OK};
    case (kind)
      KIND_APPEND: begin
        if (held_count == DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          slot = (oldest_slot + held_count) % DEPTH;
          x_mem[slot] = px;
          y_mem[slot] = py;
          held_count++;
        end
      end
      KIND_POP: begin
        if (held_count == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          oldest_slot = (oldest_slot + 1) % DEPTH;
          held_count--;
          // An emptied queue restarts at slot zero.
          if (held_count == 0) oldest_slot = 0;
        end
      end
      KIND_SEARCH_ALL: r.found = pair_held(held_count, px, py);
      KIND_SEARCH_EXCL: begin
        // The newest entry is left out, so one entry or none never matches.
        if (held_count > 1) r.found = pair_held(held_count - 1, px, py);
      end
      default: ;
    endcase
    // The response always shows the newest entry, or zero when empty.
    if (held_count != 0) begin
      slot     = (oldest_slot + held_count - 1) % DEPTH;
      r.tail_x = x_mem[slot];
      r.tail_y = y_mem[slot];
    end
    r.entry_count = COUNT_W'(held_count);
    return r;
  endfunction

  task automatic check_field(input string field, input logic [COORD_W-1:0] want_v,
                             input logic [COORD_W-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", field, want_v, got_v);
      mismatch_count++;
    end
  endtask

  // Compare each response with the oldest prediction, then record new requests.
  always @(posedge clk) begin
    if (rst) begin
      oldest_slot    = 0;
      held_count     = 0;
      mismatch_count = 0;
      pending_replies.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_replies.size() == 0) begin
          $error("response with no request waiting for it");
          mismatch_count++;
        end else begin
          want = pending_replies.pop_front();
          check_field("found", COORD_W'(want.found), COORD_W'(rsp.found));
          check_field("tail_x", want.tail_x, rsp.tail_x);
          check_field("tail_y", want.tail_y, rsp.tail_y);
          check_field("entry_count", COORD_W'(want.entry_count), COORD_W'(rsp.entry_count));
          check_field("status", COORD_W'(want.status), COORD_W'(rsp.status));
        end
      end
      if (req.valid && req.ready) begin
        pending_replies.push_back(apply_queue_op(req.kind, req.coord_x, req.coord_y));
      end
    end
    replies_outstanding <= pending_replies.size();
  end

endmodule

@@ tb/tb_coordinate_queue_with_search.sv @@
// Testbench top: clock, reset, request and response traffic, and the verdict.
`timescale 1ns / 1ps
module tb_coordinate_queue_with_search;
  import cqs_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_ITEMS = 800;
  localparam int RECENT_N     = 8;
  localparam int KIND_MAX     = (1 << KIND_W) - 1;

  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIXED
  } traffic_mode_t;

  logic        clk;
  logic        rst;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned mismatch_count;
  int unsigned replies_outstanding;

  // Pairs appended lately, reused as search keys so that searches hit.
  logic [COORD_W-1:0] recent_x [RECENT_N] = '{default: '0};
  logic [COORD_W-1:0] recent_y [RECENT_N] = '{default: '0};
  int unsigned        recent_wr = 0;

  cqs_req_if req ();
  cqs_rsp_if rsp ();

  coordinate_queue_with_search i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  coord_queue_checker i_checker (
    .clk                 (clk),
    .rst                 (rst),
    .req                 (req),
    .rsp                 (rsp),
    .mismatch_count      (mismatch_count),
    .replies_outstanding (replies_outstanding)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Response back-pressure.
  always @(posedge clk) begin
    rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles with no handshake at all.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("coordinate_queue_with_search verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(9))
      0:       return {1'b1, {(COORD_W-1){1'b0}}};
      1:       return {1'b0, {(COORD_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      4:       return COORD_W'($urandom_range(3));
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // Offers one request, with a random gap first, and waits for it to be taken.
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [COORD_W-1:0] x,
                              input logic [COORD_W-1:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid   <= 1'b1;
    req.kind    <= kind;
    req.coord_x <= x;
    req.coord_y <= y;
    do @(posedge clk); while (!req.ready);
    if (kind == KIND_APPEND) begin
      recent_x[recent_wr] = x;
      recent_y[recent_wr] = y;
      recent_wr = (recent_wr + 1) % RECENT_N;
    end
  endtask

  // Stops offering requests until every predicted response has arrived.
  task automatic drain_replies();
    req.valid <= 1'b0;
    @(posedge clk);
    while (replies_outstanding != 0) @(posedge clk);
  endtask

  task automatic send_random(input traffic_mode_t mode);
    int unsigned         roll;
    int unsigned         pick;
    int unsigned         append_pct;
    int unsigned         pop_pct;
    int unsigned         search_pct;
    logic [KIND_W-1:0]   kind;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    case (mode)
      MODE_FILL: begin
        append_pct = 75; pop_pct = 3; search_pct = 17;
      end
      MODE_DRAIN: begin
        append_pct = 10; pop_pct = 55; search_pct = 30;
      end
      default: begin
        append_pct = 35; pop_pct = 30; search_pct = 30;
      end
    endcase
    roll = $urandom_range(99);
    if (roll < append_pct) begin
      kind = KIND_APPEND;
    end else if (roll < append_pct + pop_pct) begin
      kind = KIND_POP;
    end else if (roll < append_pct + pop_pct + search_pct) begin
      kind = (roll % 2 == 0) ? KIND_SEARCH_ALL : KIND_SEARCH_EXCL;
    end else begin
      kind = KIND_W'($urandom_range(KIND_PEEK, KIND_MAX));
    end
    x = pick_coord();
    y = pick_coord();
    // Searches mostly look for a pair appended lately, sometimes one bit off.
    if (kind == KIND_SEARCH_ALL || kind == KIND_SEARCH_EXCL) begin
      roll = $urandom_range(99);
      pick = $urandom_range(RECENT_N - 1);
      if (roll < 75) begin
        x = recent_x[pick];
        y = recent_y[pick];
        if (roll >= 60) begin
          if (roll % 2 == 0) x[$urandom_range(COORD_W - 1)] ^= 1'b1;
          else y[$urandom_range(COORD_W - 1)] ^= 1'b1;
        end
      end
    end
    send_request(kind, x, y);
  endtask

  // One traffic phase: episodes of filling, draining and mixed use.
  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input int unsigned count);
    int unsigned   sent;
    int unsigned   span;
    traffic_mode_t mode;
    send_idle_pct  <= idle_pct;
    recv_stall_pct <= stall_pct;
    sent = 0;
    mode = MODE_FILL;
    span = 110;
    while (sent < count) begin
      for (int unsigned k = 0; k < span && sent < count; k++) begin
        send_random(mode);
        sent++;
      end
      mode = traffic_mode_t'($urandom_range(MODE_MIXED));
      span = $urandom_range(20, 120);
    end
  endtask

  initial begin
    rst         <= 1'b1;
    req.valid   <= 1'b0;
    req.kind    <= KIND_PEEK;
    req.coord_x <= '0;
    req.coord_y <= '0;
    repeat (7) @(posedge clk);
    rst            <= 1'b0;
    send_idle_pct  <= 10;
    recv_stall_pct <= 86;

    // Directed requests: empty queue, single entry, extremes and unused codes.
    send_request(KIND_PEEK, 16'h1234, 16'h5678);
    send_request(KIND_POP, '0, '0);
    send_request(KIND_SEARCH_ALL, '0, '0);
    send_request(KIND_SEARCH_EXCL, '0, '0);
    send_request(KIND_APPEND, 16'h7fff, 16'h8000);
    send_request(KIND_SEARCH_EXCL, 16'h7fff, 16'h8000);
    send_request(KIND_SEARCH_ALL, 16'h7fff, 16'h8000);
    send_request(KIND_POP, '0, '0);
    send_request(KIND_PEEK, '0, '0);
    send_request(KIND_APPEND, 16'h8000, 16'h7fff);
    send_request(KIND_APPEND, '0, '0);
    send_request(KIND_APPEND, 16'hffff, 16'hffff);
    send_request(KIND_SEARCH_EXCL, 16'hffff, 16'hffff);
    send_request(KIND_SEARCH_ALL, 16'hffff, 16'hffff);
    send_request(KIND_SEARCH_EXCL, 16'h8000, 16'h7fff);
    send_request(KIND_SEARCH_ALL, 16'h0000, 16'hffff);
    send_request(KIND_SEARCH_ALL, 16'hffff, 16'h0000);
    for (int k = KIND_PEEK + 1; k <= KIND_MAX; k++) begin
      send_request(KIND_W'(k), pick_coord(), pick_coord());
    end
    repeat (4) send_request(KIND_POP, pick_coord(), pick_coord());
    drain_replies();

    // Random traffic under three idling patterns.
    run_phase(10, 86, RANDOM_ITEMS / 3);
    drain_replies();
    run_phase(86, 10, RANDOM_ITEMS / 3);
    drain_replies();
    run_phase(0, 0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    drain_replies();

    repeat (DEPTH + 4) @(posedge clk);
    if (mismatch_count == 0 && replies_outstanding == 0) begin
      $display("coordinate_queue_with_search verification clean");
    end else begin
      $display("coordinate_queue_with_search verification failed");
    end
    $finish;
  end

endmodule
